// ===== src/wfc_pkg.sv =====
// Package for the word frequency counter: result status codes, default sizes
// and the byte classification helpers. No dependencies.
package wfc_pkg;

  localparam int TableDepthDef = 256;
  localparam int WordBytesDef  = 32;
  localparam int CountW        = 16;

  localparam logic [2:0] ST_EXISTING = 3'd0;
  localparam logic [2:0] ST_NEW      = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_LONG     = 3'd3;
  localparam logic [2:0] ST_END      = 3'd4;

  // True for the bytes that end a word; the zero byte is among them.
  function automatic logic is_delim(input logic [7:0] b);
    logic r;
    unique case (b)
      8'h00, 8'h20, 8'h2C, 8'h2E, 8'h2D, 8'h21, 8'h3F, 8'h3B, 8'h3A,
      8'h0A, 8'h09, 8'h22, 8'h28, 8'h29: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  // Upper-case ASCII letters become lower case; other bytes pass unchanged.
  function automatic logic [7:0] to_lower(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= 8'h41 && b <= 8'h5A) begin
      r = b + 8'd32;
    end
    return r;
  endfunction

endpackage

// ===== src/word_frequency_counter_core.sv =====
// Word frequency counter core: top level with the search and update sequencer.
// Depends on wfc_pkg and wfc_ram.
//
// Usage. Text arrives one byte per transfer on the in_ channel (in_text_byte,
// in_end_of_text). Bytes that do not end a word are taken while in_stall is
// low and written to the pending word memory. A delimiter, or the last byte
// of the text, finishes the word: the block then raises in_stall while it
// searches the table in slot order. Each slot has its entry read and length
// checked, then its bytes compared one by one when the lengths agree. A word
// that is too long, or an end of text with no word, goes straight to the
// result step; a searched word walks the table linearly through the word
// store's single read port. A new word is then copied byte by byte into the
// word store.
// One result transfer on the out_ channel follows each finished word and each
// end of text. The result sits in an output register; while the receiver
// stalls it holds, and the block still takes plain text bytes meanwhile, but a
// second result waits in the sequencer until the first has gone.
// Reset (rst_n low, synchronous) empties the table and the pending word; the
// memories themselves are not cleared, as only written entries are ever read.
module word_frequency_counter_core
  import wfc_pkg::*;
#(
  parameter int TABLE_DEPTH = TableDepthDef,
  parameter int WORD_BYTES  = WordBytesDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_text_byte,
  input  logic        in_end_of_text,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_entry_index,
  output logic [15:0] out_word_count,
  output logic [2:0]  out_status,
  output logic        out_text_done,
  output logic [8:0]  out_entries_used
);

  localparam int SW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int UW = $clog2(TABLE_DEPTH + 1);
  localparam int JW = $clog2(WORD_BYTES);
  localparam int LW = $clog2(WORD_BYTES + 1);
  localparam int WA = $clog2(TABLE_DEPTH * WORD_BYTES);
  localparam int EW = LW + CountW;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SLOT = 3'd1;
  localparam logic [2:0] S_ELEN = 3'd2;
  localparam logic [2:0] S_BCMP = 3'd3;
  localparam logic [2:0] S_NEWW = 3'd4;
  localparam logic [2:0] S_COPY = 3'd5;
  localparam logic [2:0] S_EMIT = 3'd6;

  logic [2:0]        state_r, state_nxt;
  logic [UW-1:0]     used_r, used_nxt;
  logic [UW-1:0]     i_r, i_nxt;
  logic [JW-1:0]     j_r, j_nxt;
  logic [LW-1:0]     plen_r, plen_nxt;
  logic              ovl_r, ovl_nxt;
  logic              last_r, last_nxt;
  logic [SW-1:0]     slot_r, slot_nxt;
  logic [CountW-1:0] cnt_r, cnt_nxt;
  logic [2:0]        stat_r, stat_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_idx_r, out_idx_nxt;
  logic [15:0]       out_cnt_r, out_cnt_nxt;
  logic [2:0]        out_stat_r, out_stat_nxt;
  logic              out_done_r, out_done_nxt;
  logic [8:0]        out_used_r, out_used_nxt;

  // Memory ports.
  logic              pw_we;
  logic [JW-1:0]     pw_waddr, jaddr;
  logic [7:0]        pw_rdata, ws_rdata, lower_b;
  logic              ws_we;
  logic [WA-1:0]     ws_waddr, ws_raddr;
  logic              et_we;
  logic [SW-1:0]     et_waddr, et_raddr;
  logic [EW-1:0]     et_wdata, et_rdata;

  logic              accept, delim, ends;
  logic [LW-1:0]     plen_new;
  logic              ovl_new;
  logic [SW-1:0]     i_idx, used_idx;
  logic [LW-1:0]     j_next_len;
  logic [SW+7:0]     slot_ext;
  logic [UW+8:0]     used_ext;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign delim    = is_delim(in_text_byte);
  assign lower_b  = to_lower(in_text_byte);
  assign ends     = delim || in_end_of_text;
  assign i_idx    = i_r[SW-1:0];
  assign used_idx = used_r[SW-1:0];
  assign j_next_len = LW'(j_r) + LW'(1);

  // The next byte index is what the read ports see, so data for it is
  // ready in the following cycle, when the compare or copy step wants it.
  always_comb begin
    jaddr = '0;
    if (state_r == S_BCMP || state_r == S_COPY) begin
      jaddr = JW'(j_r + JW'(1));
    end
  end

  assign ws_raddr = WA'(WA'(i_idx) * WA'(WORD_BYTES) + WA'(jaddr));
  assign ws_waddr = WA'(WA'(used_idx) * WA'(WORD_BYTES) + WA'(j_r));
  assign et_raddr = i_idx;
  assign pw_waddr = plen_r[JW-1:0];
  assign pw_we    = accept && !delim && (plen_r < LW'(WORD_BYTES));

  wfc_ram #(.Depth(WORD_BYTES), .Width(8)) u_pending (
    .clk(clk), .we(pw_we), .waddr(pw_waddr), .wdata(lower_b),
    .raddr(jaddr), .rdata(pw_rdata)
  );

  wfc_ram #(.Depth(TABLE_DEPTH * WORD_BYTES), .Width(8)) u_words (
    .clk(clk), .we(ws_we), .waddr(ws_waddr), .wdata(pw_rdata),
    .raddr(ws_raddr), .rdata(ws_rdata)
  );

  wfc_ram #(.Depth(TABLE_DEPTH), .Width(EW)) u_entries (
    .clk(clk), .we(et_we), .waddr(et_waddr), .wdata(et_wdata),
    .raddr(et_raddr), .rdata(et_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    used_nxt  = used_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    plen_nxt  = plen_r;
    ovl_nxt   = ovl_r;
    last_nxt  = last_r;
    slot_nxt  = slot_r;
    cnt_nxt   = cnt_r;
    stat_nxt  = stat_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_idx_nxt   = out_idx_r;
    out_cnt_nxt   = out_cnt_r;
    out_stat_nxt  = out_stat_r;
    out_done_nxt  = out_done_r;
    out_used_nxt  = out_used_r;
    ws_we    = 1'b0;
    et_we    = 1'b0;
    et_waddr = i_idx;
    et_wdata = '0;
    plen_new = plen_r;
    ovl_new  = ovl_r;
    slot_ext = '0;
    used_ext = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (!delim) begin
            if (plen_r < LW'(WORD_BYTES)) begin
              plen_new = plen_r + LW'(1);
            end else begin
              ovl_new = 1'b1;
            end
          end
          plen_nxt = plen_new;
          ovl_nxt  = ovl_new;
          last_nxt = in_end_of_text;
          slot_nxt = '0;
          cnt_nxt  = '0;
          if (ends && (plen_new != '0 || ovl_new)) begin
            if (ovl_new) begin
              stat_nxt  = ST_LONG;
              state_nxt = S_EMIT;
            end else begin
              i_nxt     = '0;
              state_nxt = S_SLOT;
            end
          end else if (in_end_of_text) begin
            stat_nxt  = ST_END;
            state_nxt = S_EMIT;
          end
        end
      end
      S_SLOT: begin
        if (i_r >= used_r) begin
          state_nxt = S_NEWW;
        end else begin
          state_nxt = S_ELEN;
        end
      end
      S_ELEN: begin
        j_nxt = '0;
        if (et_rdata[EW-1 -: LW] == plen_r) begin
          state_nxt = S_BCMP;
        end else begin
          i_nxt     = i_r + UW'(1);
          state_nxt = S_SLOT;
        end
      end
      S_BCMP: begin
        if (ws_rdata != pw_rdata) begin
          i_nxt     = i_r + UW'(1);
          state_nxt = S_SLOT;
        end else if (j_next_len == plen_r) begin
          cnt_nxt = et_rdata[CountW-1:0];
          if (et_rdata[CountW-1:0] != {CountW{1'b1}}) begin
            cnt_nxt = et_rdata[CountW-1:0] + CountW'(1);
          end
          et_we     = 1'b1;
          et_waddr  = i_idx;
          et_wdata  = {plen_r, cnt_nxt};
          slot_nxt  = i_idx;
          stat_nxt  = ST_EXISTING;
          state_nxt = S_EMIT;
        end else begin
          j_nxt = j_r + JW'(1);
        end
      end
      S_NEWW: begin
        j_nxt = '0;
        if (used_r >= UW'(TABLE_DEPTH)) begin
          stat_nxt  = ST_FULL;
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_COPY;
        end
      end
      S_COPY: begin
        ws_we = 1'b1;
        if (j_next_len == plen_r) begin
          et_we     = 1'b1;
          et_waddr  = used_idx;
          et_wdata  = {plen_r, CountW'(1)};
          slot_nxt  = used_idx;
          cnt_nxt   = CountW'(1);
          stat_nxt  = ST_NEW;
          used_nxt  = used_r + UW'(1);
          state_nxt = S_EMIT;
        end else begin
          j_nxt = j_r + JW'(1);
        end
      end
      S_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          slot_ext      = {8'b0, slot_r};
          used_ext      = {9'b0, used_r};
          out_valid_nxt = 1'b1;
          out_idx_nxt   = slot_ext[7:0];
          out_cnt_nxt   = cnt_r;
          out_stat_nxt  = stat_r;
          out_done_nxt  = last_r;
          out_used_nxt  = used_ext[8:0];
          plen_nxt      = '0;
          ovl_nxt       = 1'b0;
          if (last_r) begin
            used_nxt = '0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      plen_r      <= '0;
      ovl_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      plen_r      <= plen_nxt;
      ovl_r       <= ovl_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    last_r     <= last_nxt;
    slot_r     <= slot_nxt;
    cnt_r      <= cnt_nxt;
    stat_r     <= stat_nxt;
    out_idx_r  <= out_idx_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_stat_r <= out_stat_nxt;
    out_done_r <= out_done_nxt;
    out_used_r <= out_used_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_entry_index  = out_idx_r;
  assign out_word_count   = out_cnt_r;
  assign out_status       = out_stat_r;
  assign out_text_done    = out_done_r;
  assign out_entries_used = out_used_r;

  // The table never holds more entries than it has slots.
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= UW'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  // A freshly added word always reports a count of one.
  a_new_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_NEW) |-> (out_word_count == 16'd1))
    else $error("new entry with count other than one");

  // Dropped words and bare end markers carry no slot and no count.
  a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_FULL || out_status == ST_LONG ||
     out_status == ST_END)) |-> (out_word_count == 16'd0 && out_entry_index == 8'd0))
    else $error("dropped result with slot or count set");

  // An end marker is only ever produced for the last byte of the text.
  a_end_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_END) |-> out_text_done)
    else $error("end marker without text done");

endmodule

// ===== src/wfc_ram.sv =====
// Single-port-write, single-port-read synchronous RAM with registered read data.
// Used for the word store, the entry table and the pending word. Needs nothing else.
module wfc_ram #(
  parameter int Depth = 256,
  parameter int Width = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
